/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, off during arst_n low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_IMPLIES_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* design/bfge_pkg.sv */
// ----------------------------------------------------------------------------
// bfge_pkg
// Types and constants shared by the glyph expander modules
// ----------------------------------------------------------------------------
package bfge_pkg;

	localparam int MAX_GLYPHS      = 65536;
	localparam int MAX_GLYPH_BYTES = 4096;
	localparam int MAX_DIMENSION   = 256;

	// configuration register indexes
	localparam logic [1:0] REG_FG     = 2'd0;
	localparam logic [1:0] REG_BG     = 2'd1;
	localparam logic [1:0] REG_CBYTES = 2'd2;

	// header magic bytes
	localparam logic [7:0] V1_MAGIC_B0 = 8'h36;
	localparam logic [7:0] V1_MAGIC_B1 = 8'h04;
	localparam logic [7:0] V2_MAGIC_B0 = 8'h72;
	localparam logic [7:0] V2_MAGIC_B1 = 8'hB5;
	localparam logic [7:0] V2_MAGIC_B2 = 8'h4A;
	localparam logic [7:0] V2_MAGIC_B3 = 8'h86;

	// header byte positions that complete a PSF2 field
	localparam logic [5:0] POS_LENGTH   = 6'd19;
	localparam logic [5:0] POS_CHARSIZE = 6'd23;
	localparam logic [5:0] POS_HEIGHT   = 6'd27;
	localparam logic [5:0] POS_WIDTH    = 6'd31;

	typedef enum logic [3:0] {
		PH_HEADER = 4'b0001,
		PH_DATA   = 4'b0010,
		PH_DONE   = 4'b0100,
		PH_ERROR  = 4'b1000
	} phase_t;

	// one unit of work handed from front to back
	typedef struct packed {
		logic       err;
		logic [7:0] bits;
		logic [3:0] vis;
		logic       gend;
	} work_t;

	// front status toward the top
	typedef struct packed {
		logic div_busy;
		logic q_full;
	} front_stat_t;

endpackage

/* design/bfge_byte_if.sv */
// ----------------------------------------------------------------------------
// bfge_byte_if
// Font byte input channel
// ----------------------------------------------------------------------------
interface bfge_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       new_file;

	modport source (output valid, file_byte, new_file, input ready);
	modport sink (input valid, file_byte, new_file, output ready);
endinterface

/* design/bfge_pix_if.sv */
// ----------------------------------------------------------------------------
// bfge_pix_if
// Pixel result channel
// ----------------------------------------------------------------------------
interface bfge_pix_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_color;
	logic        last_of_byte;
	logic        last_of_glyph;
	logic        format_error;

	modport source (output valid, pixel_color, last_of_byte, last_of_glyph, format_error,
		input ready);
	modport sink (input valid, pixel_color, last_of_byte, last_of_glyph, format_error,
		output ready);
endinterface

/* design/bfge_cfg_if.sv */
// ----------------------------------------------------------------------------
// bfge_cfg_if
// Configuration register write channel
// ----------------------------------------------------------------------------
interface bfge_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/bfge_div.sv */
// ----------------------------------------------------------------------------
// bfge_div
// Restoring divider, one quotient bit per cycle, for bytes per glyph row
// ----------------------------------------------------------------------------
module bfge_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [12:0] dividend,
	input  logic [8:0]  divisor,
	output logic        busy,
	output logic [12:0] quotient
);
	logic [12:0] dq_q;
	logic [9:0]  rem_q;
	logic [8:0]  dvs_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic [9:0]  trial;
	logic [10:0] diff;

	// one restoring step
	always_comb begin
		trial = {rem_q[8:0], dq_q[12]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd12;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[10]) begin
				rem_q <= diff[9:0];
				dq_q  <= {dq_q[11:0], 1'b1};
			end else begin
				rem_q <= trial;
				dq_q  <= {dq_q[11:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;
endmodule

/* design/bfge_fifo.sv */
// ----------------------------------------------------------------------------
// bfge_fifo
// Two-entry work queue between header parser and pixel expander
// ----------------------------------------------------------------------------
module bfge_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bfge_pkg::work_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output bfge_pkg::work_t rdata
);
	import bfge_pkg::*;

	work_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	assign full      = cnt_q[1];
	assign not_empty = cnt_q != 2'd0;
	assign rdata     = mem_q[rp_q];
endmodule

/* design/bfge_front.sv */
// ----------------------------------------------------------------------------
// bfge_front
// Accepts font bytes, parses PSF1/PSF2 headers, tracks glyph position and
// queues one work entry per byte that yields results
// ----------------------------------------------------------------------------
module bfge_front (
	input  logic                    clk,
	input  logic                    arst_n,
	bfge_byte_if.sink               src_ch,
	input  logic                    q_full,
	output logic                    push,
	output bfge_pkg::work_t         wdata,
	output bfge_pkg::front_stat_t   stat
);
	import bfge_pkg::*;

	phase_t      phase_q, e_phase, n_phase;
	logic [5:0]  pos_q, e_pos, n_pos;
	logic        v2_q, e_v2, n_v2;
	logic [31:0] hw_q, e_hw, n_hw;
	logic [16:0] gtot_q, e_gtot, n_gtot;
	logic [12:0] gbt_q, e_gbt, n_gbt;
	logic [8:0]  gh_q, e_gh, n_gh;
	logic [8:0]  gw_q, e_gw, n_gw;
	logic [12:0] rbt_q, e_rbt, n_rbt;
	logic [16:0] gcnt_q, e_gcnt, n_gcnt;
	logic [12:0] big_q, e_big, n_big;
	logic [12:0] bir_q, e_bir, n_bir;

	logic        accept;
	logic        err;
	logic        hdr_ok;
	logic        div_start;
	logic        div_busy;
	logic [12:0] div_quot;
	logic [7:0]  b;
	logic [15:0] col0;
	logic [16:0] room;
	logic [3:0]  vis;
	logic        gend;

	assign b      = src_ch.file_byte;
	assign accept = src_ch.valid && src_ch.ready;
	assign src_ch.ready = !div_busy && !q_full;

	bfge_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (e_gbt),
		.divisor  (n_hw[8:0]),
		.busy     (div_busy),
		.quotient (div_quot)
	);

	// state seen by this byte: new_file restarts parsing
	always_comb begin
		if (src_ch.new_file) begin
			e_phase = PH_HEADER; e_pos = '0; e_v2 = 1'b0; e_hw = '0;
			e_gtot = '0; e_gbt = '0; e_gh = '0; e_gw = '0; e_rbt = '0;
			e_gcnt = '0; e_big = '0; e_bir = '0;
		end else begin
			e_phase = phase_q; e_pos = pos_q; e_v2 = v2_q; e_hw = hw_q;
			e_gtot = gtot_q; e_gbt = gbt_q; e_gh = gh_q; e_gw = gw_q; e_rbt = rbt_q;
			e_gcnt = gcnt_q; e_big = big_q; e_bir = bir_q;
		end
	end

	// visible pixels of a data byte and end of glyph
	always_comb begin
		col0 = {e_bir, 3'b000};
		room = {8'd0, e_gw} - {1'b0, col0};
		if ({7'd0, e_gw} <= col0) vis = 4'd0;
		else if (room >= 17'd8) vis = 4'd8;
		else vis = room[3:0];
		gend = ({1'b0, e_big} + 14'd1) >= {1'b0, e_gbt};
	end

	// header parse and glyph counters
	always_comb begin
		n_phase = e_phase; n_pos = e_pos; n_v2 = e_v2; n_hw = e_hw;
		n_gtot = e_gtot; n_gbt = e_gbt; n_gh = e_gh; n_gw = e_gw; n_rbt = e_rbt;
		n_gcnt = e_gcnt; n_big = e_big; n_bir = e_bir;
		err = 1'b0;
		hdr_ok = 1'b0;
		div_start = 1'b0;
		case (e_phase)
			PH_HEADER: begin
				n_pos = e_pos + 6'd1;
				n_hw  = {b, e_hw[31:8]};
				if (e_pos == 6'd0) begin
					if (b == V1_MAGIC_B0) n_v2 = 1'b0;
					else if (b == V2_MAGIC_B0) n_v2 = 1'b1;
					else err = 1'b1;
				end else if (e_pos == 6'd1) begin
					err = e_v2 ? (b != V2_MAGIC_B1) : (b != V1_MAGIC_B1);
				end else if (!e_v2) begin
					if (e_pos == 6'd2) begin
						n_gtot = b[0] ? 17'd512 : 17'd256;
					end else begin
						n_gh = {1'b0, b}; n_gbt = {5'd0, b}; n_gw = 9'd8; n_rbt = 13'd1;
						if (b == 8'd0 || 32'(b) > 32'(MAX_DIMENSION) ||
							32'(b) > 32'(MAX_GLYPH_BYTES) || 32'(e_gtot) > 32'(MAX_GLYPHS))
							err = 1'b1;
						else hdr_ok = 1'b1;
					end
				end else if (e_pos == 6'd2) begin
					err = b != V2_MAGIC_B2;
				end else if (e_pos == 6'd3) begin
					err = b != V2_MAGIC_B3;
				end else if (e_pos == POS_LENGTH) begin
					if (n_hw > 32'(MAX_GLYPHS)) err = 1'b1;
					else n_gtot = n_hw[16:0];
				end else if (e_pos == POS_CHARSIZE) begin
					if (n_hw > 32'(MAX_GLYPH_BYTES)) err = 1'b1;
					else n_gbt = n_hw[12:0];
				end else if (e_pos == POS_HEIGHT) begin
					if (n_hw == 32'd0 || n_hw > 32'(MAX_DIMENSION)) err = 1'b1;
					else begin
						n_gh = n_hw[8:0];
						div_start = accept;
					end
				end else if (e_pos == POS_WIDTH) begin
					if (n_hw > 32'(MAX_DIMENSION)) err = 1'b1;
					else begin
						n_gw  = n_hw[8:0];
						n_rbt = div_quot;
						if (div_quot == 13'd0) err = 1'b1;
						else hdr_ok = 1'b1;
					end
				end
				if (err) n_phase = PH_ERROR;
				else if (hdr_ok) n_phase = (n_gtot == 17'd0) ? PH_DONE : PH_DATA;
			end
			PH_DATA: begin
				n_big = e_big + 13'd1;
				n_bir = ((e_bir + 13'd1) >= e_rbt) ? 13'd0 : e_bir + 13'd1;
				if (gend) begin
					n_big  = '0;
					n_bir  = '0;
					n_gcnt = e_gcnt + 17'd1;
					if (n_gcnt >= e_gtot) n_phase = PH_DONE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER; pos_q <= '0; v2_q <= 1'b0; hw_q <= '0;
			gtot_q <= '0; gbt_q <= '0; gh_q <= '0; gw_q <= '0; rbt_q <= '0;
			gcnt_q <= '0; big_q <= '0; bir_q <= '0;
		end else if (accept) begin
			phase_q <= n_phase; pos_q <= n_pos; v2_q <= n_v2; hw_q <= n_hw;
			gtot_q <= n_gtot; gbt_q <= n_gbt; gh_q <= n_gh; gw_q <= n_gw; rbt_q <= n_rbt;
			gcnt_q <= n_gcnt; big_q <= n_big; bir_q <= n_bir;
		end
	end

	// queue an error or a byte with visible pixels
	assign push = accept && ((e_phase == PH_HEADER && err) ||
		(e_phase == PH_DATA && vis != 4'd0));
	assign wdata.err  = (e_phase == PH_HEADER);
	assign wdata.bits = b;
	assign wdata.vis  = vis;
	assign wdata.gend = gend;

	assign stat.div_busy = div_busy;
	assign stat.q_full   = q_full;
endmodule

/* design/bfge_back.sv */
// ----------------------------------------------------------------------------
// bfge_back
// Expands queued work into one pixel per cycle, while the pixel output is ready, behind an output register
// ----------------------------------------------------------------------------
module bfge_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_not_empty,
	input  bfge_pkg::work_t q_data,
	output logic            pop,
	input  logic [31:0]     fg_color,
	input  logic [31:0]     bg_color,
	input  logic [2:0]      color_bytes,
	bfge_pix_if.source      pix_ch
);
	import bfge_pkg::*;

	logic        busy_q;
	work_t       ent_q;
	logic [3:0]  idx_q;
	logic        ov_q;
	logic [31:0] pix_q;
	logic        lob_q, log_q, err_q;
	logic        advance;
	logic        last;
	logic [31:0] mask;

	// color mask from byte count, 0 acts as 1 and above 4 as 4
	always_comb begin
		case (color_bytes)
			3'd0, 3'd1: mask = 32'h0000_00FF;
			3'd2:       mask = 32'h0000_FFFF;
			3'd3:       mask = 32'h00FF_FFFF;
			default:    mask = 32'hFFFF_FFFF;
		endcase
	end

	assign advance = busy_q && (!ov_q || pix_ch.ready);
	assign last    = ent_q.err || (idx_q + 4'd1 == ent_q.vis);
	assign pop     = q_not_empty && (!busy_q || (advance && last));

	// current work entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (pop) begin
			busy_q <= 1'b1;
		end else if (advance && last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= q_data;
			idx_q <= '0;
		end else if (advance) begin
			ent_q.bits <= {ent_q.bits[6:0], 1'b0};
			idx_q      <= idx_q + 4'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (advance) begin
			ov_q <= 1'b1;
		end else if (pix_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_q <= ent_q.err ? 32'd0 : ((ent_q.bits[7] ? fg_color : bg_color) & mask);
			lob_q <= last;
			log_q <= !ent_q.err && last && ent_q.gend;
			err_q <= ent_q.err;
		end
	end

	assign pix_ch.valid         = ov_q;
	assign pix_ch.pixel_color   = pix_q;
	assign pix_ch.last_of_byte  = lob_q;
	assign pix_ch.last_of_glyph = log_q;
	assign pix_ch.format_error  = err_q;
endmodule

/* design/bitmap_font_glyph_expander_core.sv */
// ----------------------------------------------------------------------------
// bitmap_font_glyph_expander_core
// PSF1/PSF2 font byte stream to colored pixel stream
// ----------------------------------------------------------------------------
// A PSF2 header stalls the byte input after its height field while the row
// divider runs. Each bitmap byte becomes up to eight pixels at one pixel per
// cycle while the pixel output port is ready, so that port sets the sustained
// byte rate; bytes with no visible pixel are not queued. A two-entry queue
// sits between the header parser and the pixel expander. Write configuration
// only while idle.
module bitmap_font_glyph_expander_core (
	input  logic      clk,
	input  logic      arst_n,
	bfge_byte_if.sink src_ch,
	bfge_pix_if.source pix_ch,
	bfge_cfg_if.sink  cfg_ch
);
	import bfge_pkg::*;
	`include "assert_macros.svh"

	logic [31:0] fg_q;
	logic [31:0] bg_q;
	logic [2:0]  cb_q;
	logic        push;
	logic        pop;
	logic        q_full;
	logic        q_ne;
	work_t       wdata;
	work_t       rdata;
	front_stat_t stat;

	// configuration registers
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= 32'hFFFF_FFFF;
			bg_q <= '0;
			cb_q <= 3'd4;
		end else if (cfg_ch.valid) begin
			case (cfg_ch.index)
				REG_FG:     fg_q <= cfg_ch.data;
				REG_BG:     bg_q <= cfg_ch.data;
				REG_CBYTES: cb_q <= cfg_ch.data[2:0];
				default: ;
			endcase
		end
	end

	bfge_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.src_ch (src_ch),
		.q_full (q_full),
		.push   (push),
		.wdata  (wdata),
		.stat   (stat)
	);

	bfge_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (wdata),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_ne),
		.rdata     (rdata)
	);

	bfge_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_ne),
		.q_data      (rdata),
		.pop         (pop),
		.fg_color    (fg_q),
		.bg_color    (bg_q),
		.color_bytes (cb_q),
		.pix_ch      (pix_ch)
	);

	// error results carry no pixel and close their byte
	`ASSERT_IMPLIES(a_err_shape, pix_ch.valid && pix_ch.format_error, pix_ch.last_of_byte && !pix_ch.last_of_glyph && pix_ch.pixel_color == 32'd0)
	// a glyph ends only on the last pixel of a byte
	`ASSERT_IMPLIES(a_glyph_end, pix_ch.valid && pix_ch.last_of_glyph, pix_ch.last_of_byte)
	// no byte taken while the row divider runs or the queue is full
	`ASSERT_IMPLIES(a_in_stall, stat.div_busy || stat.q_full, !src_ch.ready)
endmodule
